// ----- rtl/core/ccm_pkg.sv -----
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared constants and widths of the column correlation matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

   localparam int MAX_ROWS   = 256;
   localparam int MAX_COLS   = 8;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

   localparam int SAMPLE_W   = 16;
   localparam int NROW_W     = 9;
   localparam int NCOL_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   localparam int MUL_X_W = 41;
   localparam int MUL_Y_W = 26;
   localparam int PROD_W  = MUL_X_W + MUL_Y_W;
   localparam int SUMA_W  = 25;
   localparam int DEV_W   = 48;
   localparam int C_W     = 49;
   localparam int ROOT_W  = 32;
   localparam int K_W     = 5;
   localparam int WIDE_W  = 64;
   localparam int DIV_Q_W = 34;
   localparam int DIV_N_W = 95;
   localparam int COEF_W  = 32;

   localparam logic [DIV_Q_W-1:0] Q30_ONE = DIV_Q_W'(34'h0_4000_0000);

endpackage

`default_nettype wire

// ----- rtl/core/ccm_ram.sv -----
// ----------------------------------------------------------------------------
// ccm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/ccm_sqrt.sv -----
// ----------------------------------------------------------------------------
// ccm_sqrt
// Normalizing square root: shifts the deviation left two bits a cycle into
// the top quarter of 64 bits, then takes one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ccm_pkg::DEV_W-1:0]   dev,
   output logic                             done,
   output logic      [ccm_pkg::ROOT_W-1:0]  root,
   output logic      [ccm_pkg::K_W-1:0]     shift
);

   localparam logic [1:0] SQ_IDLE = 2'd0;
   localparam logic [1:0] SQ_NORM = 2'd1;
   localparam logic [1:0] SQ_ITER = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [ccm_pkg::WIDE_W-1:0]    x_ff, x_in;
   logic [ccm_pkg::WIDE_W-1:0]    res_ff, res_in;
   logic [ccm_pkg::WIDE_W-1:0]    bit_ff, bit_in;
   logic [ccm_pkg::K_W-1:0]       k_ff, k_in;
   logic                          done_ff, done_in;
   logic [ccm_pkg::WIDE_W-1:0]    trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      k_in     = k_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               x_in     = {{(ccm_pkg::WIDE_W-ccm_pkg::DEV_W){1'b0}}, dev};
               k_in     = '0;
               state_in = SQ_NORM;
            end
         end
         SQ_NORM: begin
            if (x_ff[ccm_pkg::WIDE_W-1 -: 2] == 2'b00) begin
               x_in = x_ff << 2;
               k_in = k_ff + 1'b1;
            end else begin
               res_in   = '0;
               bit_in   = {2'b01, {(ccm_pkg::WIDE_W-2){1'b0}}};
               state_in = SQ_ITER;
            end
         end
         SQ_ITER: begin
            if (x_ff >= trial) begin
               x_in   = x_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               done_in  = 1'b1;
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      k_ff   <= k_in;
   end

   assign done  = done_ff;
   assign root  = res_ff[ccm_pkg::ROOT_W-1:0];
   assign shift = k_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ccm_div.sv -----
// ----------------------------------------------------------------------------
// ccm_div
// Restoring divider: one quotient bit a cycle of (m * 2^31) / den.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ccm_pkg::WIDE_W-1:0]   numer,
   input  wire logic [ccm_pkg::WIDE_W-1:0]   denom,
   output logic                              done,
   output logic      [ccm_pkg::DIV_Q_W-1:0]  quot
);

   localparam int CNT_W = $clog2(ccm_pkg::DIV_N_W);

   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [ccm_pkg::DIV_N_W-1:0]    dvd_ff, dvd_in;
   logic [ccm_pkg::WIDE_W-1:0]     rem_ff, rem_in;
   logic [ccm_pkg::WIDE_W-1:0]     den_ff, den_in;
   logic [ccm_pkg::DIV_Q_W-1:0]    q_ff, q_in;
   logic [ccm_pkg::WIDE_W:0]       rem2;
   logic [ccm_pkg::WIDE_W:0]       diff;

   assign rem2 = {rem_ff, dvd_ff[ccm_pkg::DIV_N_W-1]};
   assign diff = rem2 - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (!run_ff) begin
         if (start) begin
            run_in = 1'b1;
            cnt_in = CNT_W'(ccm_pkg::DIV_N_W - 1);
            dvd_in = {numer, {(ccm_pkg::DIV_N_W-ccm_pkg::WIDE_W){1'b0}}};
            rem_in = '0;
            den_in = denom;
            q_in   = '0;
         end
      end else begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_in = diff[ccm_pkg::WIDE_W-1:0];
            q_in   = {q_ff[ccm_pkg::DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem2[ccm_pkg::WIDE_W-1:0];
            q_in   = {q_ff[ccm_pkg::DIV_Q_W-2:0], 1'b0};
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// ----- rtl/core/column_correlation_matrix.sv -----
// ----------------------------------------------------------------------------
// column_correlation_matrix
// Pearson correlation matrix between the columns of a loaded sample matrix.
// ----------------------------------------------------------------------------
// Load: one sample per cycle while busy is low; busy rises after the last.
// Column pass: per row, read a pair and use the shared multiplier (LD_A,
// LD_B, MUL, ACC), then the deviation (D1-D3) and, if positive, its root.
// Coefficient: row walk, then divide (not on one row, zero variance or zero
// covariance); a one-cycle rsp_valid strobe each, row-major, never stalled.
// Reset: synchronous; clears the load position, returns to idle, restores
// rows_in_use and cols_in_use to 2. Sample store has no clearing pass.
`default_nettype none

module column_correlation_matrix (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [ccm_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                                   rsp_valid,
   output logic      [ccm_pkg::COL_W-1:0]         rsp_out_row,
   output logic      [ccm_pkg::COL_W-1:0]         rsp_out_col,
   output logic signed [ccm_pkg::COEF_W-1:0]      rsp_coefficient,
   output logic                                   rsp_zero_variance,
   output logic                                   rsp_last_of_matrix,
   input  wire logic                              csr_we,
   input  wire logic [ccm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ccm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_LD_A  = 5'd1;
   localparam logic [4:0] ST_LD_B  = 5'd2;
   localparam logic [4:0] ST_MUL   = 5'd3;
   localparam logic [4:0] ST_ACC   = 5'd4;
   localparam logic [4:0] ST_D1    = 5'd5;
   localparam logic [4:0] ST_D2    = 5'd6;
   localparam logic [4:0] ST_D3    = 5'd7;
   localparam logic [4:0] ST_SQ    = 5'd8;
   localparam logic [4:0] ST_PAIR  = 5'd9;
   localparam logic [4:0] ST_C1    = 5'd10;
   localparam logic [4:0] ST_C2    = 5'd11;
   localparam logic [4:0] ST_C3    = 5'd12;
   localparam logic [4:0] ST_DEN1  = 5'd13;
   localparam logic [4:0] ST_DEN2  = 5'd14;
   localparam logic [4:0] ST_DEN3  = 5'd15;
   localparam logic [4:0] ST_DIV   = 5'd16;
   localparam logic [4:0] ST_ADV   = 5'd17;

   localparam int ROW_W  = ccm_pkg::ROW_W;
   localparam int COL_W  = ccm_pkg::COL_W;
   localparam int X_W    = ccm_pkg::MUL_X_W;
   localparam int Y_W    = ccm_pkg::MUL_Y_W;
   localparam int P_W    = ccm_pkg::PROD_W;
   localparam int SA_W   = ccm_pkg::SUMA_W;
   localparam int HALF_W = ccm_pkg::ROOT_W / 2;

   // configuration
   logic [ccm_pkg::NROW_W-1:0] rows_ff, rows_in;
   logic [ccm_pkg::NCOL_W-1:0] cols_ff, cols_in;
   logic [ccm_pkg::NROW_W-1:0] n_eff;
   logic [ROW_W-1:0]           nm1;
   logic [COL_W-1:0]           ncm1;

   // sequencer
   logic [4:0]           state_ff, state_in;
   logic                 pair_mode_ff, pair_mode_in;
   logic [ROW_W-1:0]     ld_row_ff, ld_row_in;
   logic [COL_W-1:0]     ld_col_ff, ld_col_in;
   logic [ROW_W-1:0]     kk_ff, kk_in;
   logic [COL_W-1:0]     ci_ff, ci_in;
   logic [COL_W-1:0]     cj_ff, cj_in;

   // datapath
   logic signed [ccm_pkg::SAMPLE_W-1:0] a_ff, a_in;
   logic signed [SA_W-1:0]              sum_a_ff, sum_a_in;
   logic signed [X_W-1:0]               sum_p_ff, sum_p_in;
   logic signed [P_W-1:0]               prod_ff;
   logic signed [P_W-1:0]               t_ff, t_in;
   logic signed [ccm_pkg::C_W-1:0]      c_ff, c_in;
   logic [ccm_pkg::ROOT_W-1:0]          ax_ff, ax_in;
   logic [ccm_pkg::K_W-1:0]             kx_ff, kx_in;
   logic [ccm_pkg::K_W-1:0]             ky_ff, ky_in;
   logic [HALF_W-1:0]                   ay_hi_ff, ay_hi_in;
   logic signed [X_W-1:0]               mul_x;
   logic signed [Y_W-1:0]               mul_y;
   logic signed [P_W-1:0]               diff;

   // per-column results
   logic signed [SA_W-1:0]        mean_ff [ccm_pkg::MAX_COLS];
   logic [ccm_pkg::ROOT_W-1:0]    root_ff [ccm_pkg::MAX_COLS];
   logic [ccm_pkg::K_W-1:0]       kcol_ff [ccm_pkg::MAX_COLS];
   logic [ccm_pkg::MAX_COLS-1:0]  zf_ff;
   logic                          col_we;
   logic                          col_zero;
   logic [COL_W-1:0]              col_rd;

   // result registers
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [ccm_pkg::COEF_W-1:0] coef_ff, coef_in;
   logic                          zv_ff, zv_in;

   // sample store
   logic                          ram_we;
   logic [ccm_pkg::ADDR_W-1:0]    ram_waddr;
   logic [ccm_pkg::ADDR_W-1:0]    ram_raddr;
   logic [ccm_pkg::SAMPLE_W-1:0]  ram_rdata;

   // shared units
   logic                          sq_start;
   logic                          sq_done;
   logic [ccm_pkg::ROOT_W-1:0]    sq_root;
   logic [ccm_pkg::K_W-1:0]       sq_shift;
   logic                          div_start;
   logic                          div_done;
   logic [ccm_pkg::DIV_Q_W-1:0]   div_q;
   logic [ccm_pkg::WIDE_W-1:0]    div_numer;
   logic [ccm_pkg::WIDE_W-1:0]    div_denom;
   logic [ccm_pkg::DEV_W-1:0]     c_abs;
   logic [5:0]                    shift_sum;
   logic [ccm_pkg::DIV_Q_W:0]     q_round;
   logic [ccm_pkg::DIV_Q_W-1:0]   mag;
   logic [ccm_pkg::DIV_Q_W-1:0]   mag_sat;

   always_comb begin
      if (rows_ff == '0) begin
         n_eff = ccm_pkg::NROW_W'(1);
      end else if (rows_ff > ccm_pkg::NROW_W'(ccm_pkg::MAX_ROWS)) begin
         n_eff = ccm_pkg::NROW_W'(ccm_pkg::MAX_ROWS);
      end else begin
         n_eff = rows_ff;
      end
      if (cols_ff == '0) begin
         ncm1 = '0;
      end else if (cols_ff > ccm_pkg::NCOL_W'(ccm_pkg::MAX_COLS)) begin
         ncm1 = COL_W'(ccm_pkg::MAX_COLS - 1);
      end else begin
         ncm1 = COL_W'(cols_ff - 1'b1);
      end
   end

   assign nm1  = ROW_W'(n_eff - 1'b1);
   assign busy = (state_ff != ST_IDLE);

   assign ram_we    = start && !busy;
   assign ram_waddr = {ld_col_ff, ld_row_ff};
   assign ram_raddr = (state_ff == ST_LD_B) ? {cj_ff, kk_ff} : {ci_ff, kk_ff};

   ccm_ram #(
      .WIDTH (ccm_pkg::SAMPLE_W),
      .DEPTH (ccm_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_sample_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign col_rd = (state_ff == ST_C3) ? ci_ff : cj_ff;

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      unique case (state_ff)
         ST_MUL: begin
            mul_x = X_W'(a_ff);
            mul_y = Y_W'($signed(ram_rdata));
         end
         ST_D1, ST_C1: begin
            mul_x = sum_p_ff;
            mul_y = $signed({{(Y_W-ccm_pkg::NROW_W){1'b0}}, n_eff});
         end
         ST_D2: begin
            mul_x = X_W'(sum_a_ff);
            mul_y = Y_W'(sum_a_ff);
         end
         ST_C2: begin
            mul_x = X_W'(sum_a_ff);
            mul_y = Y_W'(mean_ff[col_rd]);
         end
         ST_DEN1: begin
            mul_x = $signed({{(X_W-ccm_pkg::ROOT_W){1'b0}}, ax_ff});
            mul_y = $signed({{(Y_W-HALF_W){1'b0}}, root_ff[col_rd][HALF_W-1:0]});
         end
         ST_DEN2: begin
            mul_x = $signed({{(X_W-ccm_pkg::ROOT_W){1'b0}}, ax_ff});
            mul_y = $signed({{(Y_W-HALF_W){1'b0}}, ay_hi_ff});
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign diff      = t_ff - prod_ff;
   assign c_abs     = c_ff[ccm_pkg::C_W-1] ? ccm_pkg::DEV_W'(-c_ff)
                                           : c_ff[ccm_pkg::DEV_W-1:0];
   assign shift_sum = {1'b0, kx_ff} + {1'b0, ky_ff};
   assign div_numer = {{(ccm_pkg::WIDE_W-ccm_pkg::DEV_W){1'b0}}, c_abs} << shift_sum;
   assign div_denom = t_ff[ccm_pkg::WIDE_W-1:0]
                    + {prod_ff[ccm_pkg::WIDE_W-HALF_W-1:0], {HALF_W{1'b0}}};
   assign q_round   = {1'b0, div_q} + 1'b1;
   assign mag       = q_round[ccm_pkg::DIV_Q_W:1];
   assign mag_sat   = (mag > ccm_pkg::Q30_ONE) ? ccm_pkg::Q30_ONE : mag;

   ccm_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .dev   (diff[ccm_pkg::DEV_W-1:0]),
      .done  (sq_done),
      .root  (sq_root),
      .shift (sq_shift)
   );

   ccm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      pair_mode_in = pair_mode_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      ld_row_in    = ld_row_ff;
      ld_col_in    = ld_col_ff;
      kk_in        = kk_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      a_in         = a_ff;
      sum_a_in     = sum_a_ff;
      sum_p_in     = sum_p_ff;
      t_in         = t_ff;
      c_in         = c_ff;
      ax_in        = ax_ff;
      kx_in        = kx_ff;
      ky_in        = ky_ff;
      ay_hi_in     = ay_hi_ff;
      rsp_valid_in = 1'b0;
      coef_in      = coef_ff;
      zv_in        = zv_ff;
      col_we       = 1'b0;
      col_zero     = 1'b0;
      sq_start     = 1'b0;
      div_start    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            ccm_pkg::CSR_ROWS: rows_in = csr_wdata;
            ccm_pkg::CSR_COLS: cols_in = csr_wdata[ccm_pkg::NCOL_W-1:0];
            default: begin
            end
         endcase
         ld_row_in = '0;
         ld_col_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (ld_row_ff == nm1) begin
                  ld_row_in = '0;
                  if (ld_col_ff == ncm1) begin
                     ld_col_in    = '0;
                     ci_in        = '0;
                     cj_in        = '0;
                     kk_in        = '0;
                     sum_a_in     = '0;
                     sum_p_in     = '0;
                     pair_mode_in = 1'b0;
                     state_in     = ST_LD_A;
                  end else begin
                     ld_col_in = ld_col_ff + 1'b1;
                  end
               end else begin
                  ld_row_in = ld_row_ff + 1'b1;
               end
            end
         end
         ST_LD_A: state_in = ST_LD_B;
         ST_LD_B: begin
            a_in     = $signed(ram_rdata);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            sum_a_in = sum_a_ff + SA_W'(a_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_p_in = sum_p_ff + prod_ff[X_W-1:0];
            if (kk_ff == nm1) begin
               state_in = pair_mode_ff ? ST_C1 : ST_D1;
            end else begin
               kk_in    = kk_ff + 1'b1;
               state_in = ST_LD_A;
            end
         end
         ST_D1: state_in = ST_D2;
         ST_D2: begin
            t_in     = prod_ff;
            state_in = ST_D3;
         end
         ST_D3: begin
            col_we = 1'b1;
            if (diff <= 0) begin
               col_zero = 1'b1;
               if (ci_ff == ncm1) begin
                  ci_in        = '0;
                  cj_in        = '0;
                  pair_mode_in = 1'b1;
                  state_in     = ST_PAIR;
               end else begin
                  ci_in    = ci_ff + 1'b1;
                  cj_in    = ci_ff + 1'b1;
                  kk_in    = '0;
                  sum_a_in = '0;
                  sum_p_in = '0;
                  state_in = ST_LD_A;
               end
            end else begin
               sq_start = 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (sq_done) begin
               if (ci_ff == ncm1) begin
                  ci_in        = '0;
                  cj_in        = '0;
                  pair_mode_in = 1'b1;
                  state_in     = ST_PAIR;
               end else begin
                  ci_in    = ci_ff + 1'b1;
                  cj_in    = ci_ff + 1'b1;
                  kk_in    = '0;
                  sum_a_in = '0;
                  sum_p_in = '0;
                  state_in = ST_LD_A;
               end
            end
         end
         ST_PAIR: begin
            kk_in    = '0;
            sum_a_in = '0;
            sum_p_in = '0;
            if (nm1 == '0) begin
               coef_in      = '0;
               zv_in        = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_ADV;
            end else if (zf_ff[ci_ff] || zf_ff[cj_ff]) begin
               coef_in      = '0;
               zv_in        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ADV;
            end else begin
               state_in = ST_LD_A;
            end
         end
         ST_C1: state_in = ST_C2;
         ST_C2: begin
            t_in     = prod_ff;
            state_in = ST_C3;
         end
         ST_C3: begin
            c_in     = diff[ccm_pkg::C_W-1:0];
            ax_in    = root_ff[col_rd];
            kx_in    = kcol_ff[col_rd];
            state_in = ST_DEN1;
         end
         ST_DEN1: begin
            ky_in    = kcol_ff[col_rd];
            ay_hi_in = root_ff[col_rd][ccm_pkg::ROOT_W-1:HALF_W];
            state_in = ST_DEN2;
         end
         ST_DEN2: begin
            t_in     = prod_ff;
            state_in = ST_DEN3;
         end
         ST_DEN3: begin
            if (c_ff == '0) begin
               coef_in      = '0;
               zv_in        = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_ADV;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               coef_in      = c_ff[ccm_pkg::C_W-1]
                            ? -$signed(ccm_pkg::COEF_W'(mag_sat))
                            : $signed(ccm_pkg::COEF_W'(mag_sat));
               zv_in        = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_ADV;
            end
         end
         ST_ADV: begin
            if (cj_ff == ncm1) begin
               cj_in = '0;
               if (ci_ff == ncm1) begin
                  ci_in    = '0;
                  state_in = ST_IDLE;
               end else begin
                  ci_in    = ci_ff + 1'b1;
                  state_in = ST_PAIR;
               end
            end else begin
               cj_in    = cj_ff + 1'b1;
               state_in = ST_PAIR;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pair_mode_ff <= 1'b0;
         rows_ff      <= ccm_pkg::NROW_W'(2);
         cols_ff      <= ccm_pkg::NCOL_W'(2);
         ld_row_ff    <= '0;
         ld_col_ff    <= '0;
         kk_ff        <= '0;
         ci_ff        <= '0;
         cj_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pair_mode_ff <= pair_mode_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         ld_row_ff    <= ld_row_in;
         ld_col_ff    <= ld_col_in;
         kk_ff        <= kk_in;
         ci_ff        <= ci_in;
         cj_ff        <= cj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff     <= a_in;
      sum_a_ff <= sum_a_in;
      sum_p_ff <= sum_p_in;
      prod_ff  <= mul_x * mul_y;
      t_ff     <= t_in;
      c_ff     <= c_in;
      ax_ff    <= ax_in;
      kx_ff    <= kx_in;
      ky_ff    <= ky_in;
      ay_hi_ff <= ay_hi_in;
      coef_ff  <= coef_in;
      zv_ff    <= zv_in;
      if (col_we) begin
         mean_ff[ci_ff] <= sum_a_ff;
         zf_ff[ci_ff]   <= col_zero;
      end
      if (sq_done) begin
         root_ff[ci_ff] <= sq_root;
         kcol_ff[ci_ff] <= sq_shift;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_row        = ci_ff;
   assign rsp_out_col        = cj_ff;
   assign rsp_coefficient    = coef_ff;
   assign rsp_zero_variance  = zv_ff;
   assign rsp_last_of_matrix = rsp_valid_ff && (ci_ff == ncm1) && (cj_ff == ncm1);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("sample written outside load phase");

   a_div_nonzero_var: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !(zf_ff[ci_ff] || zf_ff[cj_ff]) && (c_ff != '0))
      else $error("divide started on zero-variance pair or zero covariance");

   a_zero_var_coef: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_variance |-> rsp_coefficient == '0)
      else $error("zero-variance result with nonzero coefficient");

   a_last_in_pairs: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_matrix |=> state_ff == ST_IDLE)
      else $error("last result not followed by return to idle");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for column_correlation_matrix: loads sample matrices of
// many shapes, predicts every correlation coefficient in fixed point and
// compares each strobed coefficient with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   typedef struct packed {
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] coef;
      logic               zero_var;
      logic               last;
   } coef_type;

   logic clock, reset, start, busy, csr_we;
   logic signed [ccm_pkg::SAMPLE_W-1:0] req_sample_value;
   logic rsp_valid, rsp_zero_variance, rsp_last_of_matrix;
   logic [ccm_pkg::COL_W-1:0] rsp_out_row, rsp_out_col;
   logic signed [ccm_pkg::COEF_W-1:0] rsp_coefficient;
   logic [ccm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ccm_pkg::CSR_DATA_W-1:0] csr_wdata;

   localparam logic [ccm_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [ccm_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int QUIET_LIMIT = 60000;
   localparam int ITEM_TARGET = 410;

   column_correlation_matrix u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample_value(req_sample_value),
      .rsp_valid(rsp_valid), .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_coefficient(rsp_coefficient), .rsp_zero_variance(rsp_zero_variance),
      .rsp_last_of_matrix(rsp_last_of_matrix),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   coef_type coef_queue[$];
   logic [ccm_pkg::NROW_W-1:0] rows_reg;
   logic [ccm_pkg::NCOL_W-1:0] cols_reg;
   logic signed [15:0] sample_store [ccm_pkg::MAX_COLS][ccm_pkg::MAX_ROWS];
   int load_count;
   int error_count;
   int items_sent;
   int quiet_cycles;
   bit no_idle;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > ccm_pkg::MAX_ROWS) return ccm_pkg::MAX_ROWS;
      return int'(rows_reg);
   endfunction

   function automatic int eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > ccm_pkg::MAX_COLS) return ccm_pkg::MAX_COLS;
      return int'(cols_reg);
   endfunction

   function automatic bit [63:0] floor_root(bit [63:0] d);
      bit [63:0] root;
      bit [64:0] cand;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         cand = {1'b0, root | (64'd1 << i)};
         if (cand * cand <= {1'b0, d}) root = cand[63:0];
      end
      return root;
   endfunction

   function automatic logic signed [31:0] fixed_coef(longint c, longint dx, longint dy);
      bit [63:0] nx, ny, ax, ay, den, m, q;
      bit [127:0] num;
      int kx, ky;
      bit neg;
      if (c == 0) return 0;
      neg = c < 0;
      nx = dx;
      ny = dy;
      kx = 0;
      ky = 0;
      while (nx < 64'h4000_0000_0000_0000) begin
         nx = nx << 2;
         kx++;
      end
      while (ny < 64'h4000_0000_0000_0000) begin
         ny = ny << 2;
         ky++;
      end
      ax = floor_root(nx);
      ay = floor_root(ny);
      den = ax * ay;
      m = neg ? -c : c;
      m = m << (kx + ky);
      num = {64'd0, m} << 31;
      q = 64'(num / {64'd0, den});
      q = (q + 1) >> 1;
      if (q > 64'd1073741824) q = 64'd1073741824;
      return neg ? -32'(q) : 32'(q);
   endfunction

   task automatic predict_matrix(int n, int nc);
      longint col_sum [ccm_pkg::MAX_COLS];
      longint col_dev [ccm_pkg::MAX_COLS];
      longint sxx, sxy;
      coef_type e;
      for (int i = 0; i < nc; i++) begin
         col_sum[i] = 0;
         sxx = 0;
         for (int k = 0; k < n; k++) begin
            col_sum[i] += sample_store[i][k];
            sxx += longint'(sample_store[i][k]) * sample_store[i][k];
         end
         col_dev[i] = n * sxx - col_sum[i] * col_sum[i];
      end
      for (int i = 0; i < nc; i++) begin
         for (int j = 0; j < nc; j++) begin
            e.row = 3'(i);
            e.col = 3'(j);
            e.coef = 0;
            e.zero_var = 1'b0;
            e.last = (i == nc - 1) && (j == nc - 1);
            if (n > 1) begin
               if (col_dev[i] <= 0 || col_dev[j] <= 0) begin
                  e.zero_var = 1'b1;
               end else begin
                  sxy = 0;
                  for (int k = 0; k < n; k++)
                     sxy += longint'(sample_store[i][k]) * sample_store[j][k];
                  e.coef = fixed_coef(n * sxy - col_sum[i] * col_sum[j],
                                      col_dev[i], col_dev[j]);
               end
            end
            coef_queue.push_back(e);
         end
      end
   endtask

   task automatic load_sample(logic signed [15:0] v);
      int n, nc;
      n = eff_rows();
      nc = eff_cols();
      if (load_count >= n * nc) load_count = 0;
      sample_store[load_count / n][load_count % n] = v;
      load_count++;
      if (load_count == n * nc) begin
         load_count = 0;
         predict_matrix(n, nc);
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_sample(logic signed [15:0] v);
      int gap;
      start <= 1'b1;
      req_sample_value <= v;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      load_sample(v);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (coef_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [ccm_pkg::CSR_IDX_W-1:0] idx,
                            logic [ccm_pkg::CSR_DATA_W-1:0] data);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == ccm_pkg::CSR_ROWS) rows_reg = data;
      else if (idx == ccm_pkg::CSR_COLS) cols_reg = data[ccm_pkg::NCOL_W-1:0];
      load_count = 0;
   endtask

   task automatic test_reset_shape();
      send_sample(-16'sd32768);
      send_sample(16'sd32767);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
   endtask

   task automatic test_single_row();
      write_csr(ccm_pkg::CSR_ROWS, 9'd1);
      write_csr(ccm_pkg::CSR_COLS, 9'd3);
      send_sample(16'sd5);
      send_sample(-16'sd7);
      send_sample(16'sd0);
   endtask

   task automatic test_zero_variance();
      write_csr(ccm_pkg::CSR_ROWS, 9'd3);
      write_csr(ccm_pkg::CSR_COLS, 9'd2);
      repeat (3) send_sample(16'sd100);
      send_sample(16'sd1);
      send_sample(-16'sd2);
      send_sample(16'sd3);
   endtask

   task automatic test_full_correlation();
      write_csr(ccm_pkg::CSR_COLS, 9'd3);
      send_sample(16'sd10);
      send_sample(-16'sd300);
      send_sample(16'sd77);
      send_sample(16'sd10);
      send_sample(-16'sd300);
      send_sample(16'sd77);
      send_sample(-16'sd10);
      send_sample(16'sd300);
      send_sample(-16'sd77);
   endtask

   task automatic test_discard();
      send_sample(16'sd1234);
      send_sample(-16'sd4321);
      write_csr(CSR_SPARE_A, 9'h1FF);
      send_sample(16'sd9);
      write_csr(CSR_SPARE_B, 9'h155);
      repeat (6) send_sample(16'($urandom));
   endtask

   task automatic test_range_clamp();
      write_csr(ccm_pkg::CSR_ROWS, 9'd0);
      write_csr(ccm_pkg::CSR_COLS, 9'd15);
      repeat (8) send_sample(16'($urandom));
      write_csr(ccm_pkg::CSR_ROWS, 9'h1FF);
      write_csr(ccm_pkg::CSR_COLS, 9'd0);
      repeat (256) send_sample(16'($urandom));
      write_csr(ccm_pkg::CSR_ROWS, 9'd256);
      write_csr(ccm_pkg::CSR_COLS, 9'd8);
      repeat (8) write_csr(ccm_pkg::CSR_ROWS, 9'd2);
      repeat (16) send_sample(16'($urandom));
   endtask

   function automatic logic signed [15:0] rand_sample(int kind, logic signed [15:0] base);
      case (kind)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 8)) - 16'sd4;
         2: return base;
         default: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      endcase
   endfunction

   task automatic test_random();
      int n, nc, kind, mats;
      logic signed [15:0] first_col [ccm_pkg::MAX_ROWS];
      logic signed [15:0] v, base;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(16, 48);
            nc = $urandom_range(1, 3);
         end else begin
            n = $urandom_range(1, 8);
            nc = $urandom_range(1, 8);
         end
         write_csr(ccm_pkg::CSR_ROWS, 9'(n));
         write_csr(ccm_pkg::CSR_COLS, 9'(nc));
         no_idle = ($urandom_range(0, 3) == 0);
         mats = $urandom_range(1, 3);
         for (int m = 0; m < mats && items_sent < ITEM_TARGET; m++) begin
            for (int c = 0; c < nc; c++) begin
               kind = $urandom_range(0, 9);
               base = 16'($urandom);
               for (int r = 0; r < n; r++) begin
                  if (c > 0 && kind == 8) v = first_col[r];
                  else if (c > 0 && kind == 9) v = -first_col[r];
                  else v = rand_sample(kind < 5 ? 0 : kind - 4, base);
                  if (c == 0) first_col[r] = v;
                  send_sample(v);
               end
            end
         end
         if (items_sent < ITEM_TARGET && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, n * nc)) send_sample(16'($urandom));
            write_csr(2'($urandom_range(0, 3)), 9'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      coef_type e;
      if (!reset && rsp_valid) begin
         if (coef_queue.size() == 0) begin
            $display("%0t unexpected coefficient: expected none, actual row %0d col %0d value %0d",
                     $time, rsp_out_row, rsp_out_col, rsp_coefficient);
            error_count++;
         end else begin
            e = coef_queue.pop_front();
            if (rsp_out_row !== e.row) begin
               $display("%0t out_row: expected %0d actual %0d", $time, e.row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== e.col) begin
               $display("%0t out_col: expected %0d actual %0d", $time, e.col, rsp_out_col);
               error_count++;
            end
            if (rsp_coefficient !== e.coef) begin
               $display("%0t coefficient: expected %0d actual %0d",
                        $time, e.coef, rsp_coefficient);
               error_count++;
            end
            if (rsp_zero_variance !== e.zero_var) begin
               $display("%0t zero_variance: expected %0b actual %0b",
                        $time, e.zero_var, rsp_zero_variance);
               error_count++;
            end
            if (rsp_last_of_matrix !== e.last) begin
               $display("%0t last_of_matrix: expected %0b actual %0b",
                        $time, e.last, rsp_last_of_matrix);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_sample_value = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rows_reg = 9'd2;
      cols_reg = 4'd2;
      load_count = 0;
      error_count = 0;
      items_sent = 0;
      quiet_cycles = 0;
      no_idle = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_shape();
      test_single_row();
      test_zero_variance();
      test_full_correlation();
      test_discard();
      test_range_clamp();
      test_random();
      wait_idle();
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- column_correlation_matrix.f -----
rtl/core/ccm_pkg.sv
rtl/core/ccm_ram.sv
rtl/core/ccm_sqrt.sv
rtl/core/ccm_div.sv
rtl/core/column_correlation_matrix.sv
tb/sv/tb_top.sv
